// ===== src/sobel_edge_magnitude_rgb_core_defines.svh =====
// Assertion macros shared by the Sobel edge magnitude RTL
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SEM_ASSERT_NOW(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SEM_ASSERT_NEXT(label, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");

`endif

// ===== src/sem_pkg.sv =====
// Shared constants and types of the Sobel edge magnitude block
`default_nettype none
package sem_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W  = 11;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CNT_W  = 21;
  localparam int PIX_W  = 24;
  localparam int SQ_W   = 22;

  localparam logic CFG_WIDTH  = 1'b0;
  localparam logic CFG_HEIGHT = 1'b1;

  typedef struct packed {
    logic accept;
    logic shift;
    logic grad;
    logic sqrt_step;
    logic load_out;
  } sem_cmd_t;

  typedef struct packed {
    logic has_res;
    logic sqrt_last;
    logic out_valid;
  } sem_sts_t;
endpackage
`default_nettype wire

// ===== src/sem_ram.sv =====
// Generic single write, single registered read RAM
`default_nettype none
module sem_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ===== src/sem_ctrl.sv =====
// Sequencing state machine of the Sobel edge magnitude block
`default_nettype none
`include "sobel_edge_magnitude_rgb_core_defines.svh"
module sem_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              out_stall,
  input  wire sem_pkg::sem_sts_t sts,
  output sem_pkg::sem_cmd_t      cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_GRAD  = 3'd2;
  localparam logic [2:0] S_SQRT  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        state_nxt = sts.has_res ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad = 1'b1;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!sts.out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `SEM_ASSERT_NOW(a_load_free, cmd.load_out, !sts.out_valid || !out_stall)
  `SEM_ASSERT_NEXT(a_accept_shift, cmd.accept, state_r == S_SHIFT)
  `SEM_ASSERT_NEXT(a_sqrt_hold, cmd.sqrt_step && !sts.sqrt_last, state_r == S_SQRT)
endmodule
`default_nettype wire

// ===== src/sem_datapath.sv =====
// Line buffers, window, gradient and square root datapath
`default_nettype none
module sem_datapath (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire sem_pkg::sem_cmd_t        cmd,
  output sem_pkg::sem_sts_t             sts,
  input  wire logic                     cfg_we,
  input  wire logic                     cfg_index,
  input  wire logic [sem_pkg::DIM_W-1:0] cfg_wdata,
  input  wire logic                     in_func,
  input  wire logic [7:0]               in_red_in,
  input  wire logic [7:0]               in_green_in,
  input  wire logic [7:0]               in_blue_in,
  input  wire logic                     out_stall,
  output logic                          out_valid,
  output logic [7:0]                    out_red_out,
  output logic [7:0]                    out_green_out,
  output logic [7:0]                    out_blue_out,
  output logic                          out_frame_last
);
  localparam int DW = sem_pkg::DIM_W;
  localparam int CW = sem_pkg::COL_W;
  localparam int NW = sem_pkg::CNT_W;
  localparam int PW = sem_pkg::PIX_W;
  localparam int SW = sem_pkg::SQ_W;

  logic [DW-1:0] width_r, height_r, w, h;
  logic [NW-1:0] total;
  logic [CW-1:0] col_r;
  logic [DW-1:0] row_r;
  logic [NW-1:0] cnt_r;
  logic [PW-1:0] pix_r;
  logic [PW-1:0] up_d, mid_d;
  logic [PW-1:0] win_r [3][3];
  logic [2:0]    rowok_r, colok_r;
  logic          fl_r;
  logic [SW-1:0] rem_r [3];
  logic [SW-1:0] root_r [3];
  logic [SW-1:0] bit_r;
  logic          ov_r;
  logic [7:0]    mag_r [3];
  logic          flo_r;

  always_comb begin
    w = (width_r == '0) ? DW'(1) : ((width_r > DW'(sem_pkg::MAX_WIDTH)) ?
        DW'(sem_pkg::MAX_WIDTH) : width_r);
    h = (height_r == '0) ? DW'(1) : ((height_r > DW'(sem_pkg::MAX_HEIGHT)) ?
        DW'(sem_pkg::MAX_HEIGHT) : height_r);
  end
  assign total = NW'(w) * NW'(h);

  sem_ram #(.WIDTH(PW), .DEPTH(sem_pkg::MAX_WIDTH)) u_upper (
    .clk(clk), .we(cmd.shift), .waddr(col_r), .wdata(mid_d),
    .re(cmd.accept), .raddr(col_r), .rdata(up_d)
  );
  sem_ram #(.WIDTH(PW), .DEPTH(sem_pkg::MAX_WIDTH)) u_middle (
    .clk(clk), .we(cmd.shift), .waddr(col_r), .wdata(pix_r),
    .re(cmd.accept), .raddr(col_r), .rdata(mid_d)
  );

  // position bookkeeping for the shift cycle
  logic          started, res, done;
  logic [NW-1:0] cnt_inc;
  logic [DW-1:0] c_ext, ci, cj;
  always_comb begin
    c_ext   = DW'(col_r);
    started = (row_r >= DW'(2)) || (row_r == DW'(1) && col_r != '0);
    res     = started && (cnt_r < total);
    cnt_inc = cnt_r + NW'(1);
    done    = res ? (cnt_inc >= total) : started;
    ci      = (col_r == '0) ? row_r - DW'(2) : row_r - DW'(1);
    cj      = (col_r == '0) ? w - DW'(1) : c_ext - DW'(1);
  end

  assign sts.has_res   = res;
  assign sts.sqrt_last = bit_r[0];
  assign sts.out_valid = ov_r;

  // gradients
  logic [SW-1:0] s [3];
  always_comb begin
    logic [7:0] p [3][3];
    logic signed [11:0] gx, gy;
    logic signed [23:0] qx, qy;
    for (int ch = 0; ch < 3; ch++) begin
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          p[y][x] = (rowok_r[y] && colok_r[x]) ? win_r[y][x][16-8*ch +: 8] : 8'd0;
        end
      end
      gx = -$signed({4'd0, p[0][0]}) + $signed({4'd0, p[0][2]})
           - 12'sd2 * $signed({4'd0, p[1][0]}) + 12'sd2 * $signed({4'd0, p[1][2]})
           - $signed({4'd0, p[2][0]}) + $signed({4'd0, p[2][2]});
      gy = -$signed({4'd0, p[0][0]}) - 12'sd2 * $signed({4'd0, p[0][1]})
           - $signed({4'd0, p[0][2]}) + $signed({4'd0, p[2][0]})
           + 12'sd2 * $signed({4'd0, p[2][1]}) + $signed({4'd0, p[2][2]});
      qx = 24'(gx) * 24'(gx);
      qy = 24'(gy) * 24'(gy);
      s[ch] = SW'(qx) + SW'(qy);
    end
  end

  // rounding and saturation of the finished roots
  logic [7:0] mag [3];
  always_comb begin
    logic [SW-1:0] rt;
    for (int ch = 0; ch < 3; ch++) begin
      rt = (rem_r[ch] > root_r[ch]) ? root_r[ch] + SW'(1) : root_r[ch];
      mag[ch] = (rt > SW'(255)) ? 8'd255 : rt[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DW'(sem_pkg::MAX_WIDTH);
      height_r <= DW'(sem_pkg::MAX_HEIGHT);
      col_r    <= '0;
      row_r    <= '0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
      bit_r    <= '0;
      for (int y = 0; y < 3; y++) begin
        for (int x = 0; x < 3; x++) begin
          win_r[y][x] <= '0;
        end
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == sem_pkg::CFG_WIDTH) begin
          width_r <= cfg_wdata;
        end else begin
          height_r <= cfg_wdata;
        end
      end
      if (cmd.shift) begin
        for (int y = 0; y < 3; y++) begin
          win_r[y][0] <= win_r[y][1];
          win_r[y][1] <= win_r[y][2];
        end
        win_r[0][2] <= up_d;
        win_r[1][2] <= mid_d;
        win_r[2][2] <= pix_r;
        if (res) begin
          cnt_r <= cnt_inc;
        end
        if (done) begin
          col_r <= '0;
          row_r <= '0;
          cnt_r <= '0;
        end else if (c_ext + DW'(1) >= w) begin
          col_r <= '0;
          row_r <= row_r + DW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (cmd.grad) begin
        bit_r <= SW'(1) << (SW - 2);
      end else if (cmd.sqrt_step) begin
        bit_r <= bit_r >> 2;
      end
      if (cmd.load_out) begin
        ov_r <= 1'b1;
      end else if (!out_stall) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix_r <= (!in_func && row_r < h) ? {in_red_in, in_green_in, in_blue_in} : '0;
    end
    if (cmd.shift) begin
      rowok_r <= {(ci + DW'(1) < h), 1'b1, (ci != '0)};
      colok_r <= {(cj + DW'(1) < w), 1'b1, (cj != '0)};
      fl_r    <= done;
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.grad) begin
        rem_r[ch]  <= s[ch];
        root_r[ch] <= '0;
      end else if (cmd.sqrt_step) begin
        if (rem_r[ch] >= root_r[ch] + bit_r) begin
          rem_r[ch]  <= rem_r[ch] - (root_r[ch] + bit_r);
          root_r[ch] <= (root_r[ch] >> 1) + bit_r;
        end else begin
          root_r[ch] <= root_r[ch] >> 1;
        end
      end
    end
    if (cmd.load_out) begin
      for (int ch = 0; ch < 3; ch++) begin
        mag_r[ch] <= mag[ch];
      end
      flo_r <= fl_r;
    end
  end

  assign out_valid      = ov_r;
  assign out_red_out    = mag_r[0];
  assign out_green_out  = mag_r[1];
  assign out_blue_out   = mag_r[2];
  assign out_frame_last = flo_r;
endmodule
`default_nettype wire

// ===== src/sobel_edge_magnitude_rgb_core.sv =====
// Top level of the streaming 3x3 Sobel edge magnitude block for RGB pixels
// Pixels enter in raster order, one item at a time. An item that gives no
// result goes through a line buffer read, then a window shift. An item that
// gives a result goes through those two, then the gradients and squares, the
// bit-pair square root and the hand-over of the result to the output
// register, which lets the next item in while a result waits. The hand-over
// is held for as long as an earlier result is still stalled at the output.
// Results lag the input by one row plus one pixel; width+1 drain items flush
// a frame, and the final result carries frame_last. The line buffers need no
// clearing after reset.
`default_nettype none
module sobel_edge_magnitude_rgb_core (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic                      cfg_index,
  input  wire logic [sem_pkg::DIM_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_func,
  input  wire logic [7:0]                in_red_in,
  input  wire logic [7:0]                in_green_in,
  input  wire logic [7:0]                in_blue_in,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [7:0]                     out_red_out,
  output logic [7:0]                     out_green_out,
  output logic [7:0]                     out_blue_out,
  output logic                           out_frame_last
);
  sem_pkg::sem_cmd_t cmd;
  sem_pkg::sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .sts(sts), .cmd(cmd)
  );

  sem_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_func(in_func), .in_red_in(in_red_in), .in_green_in(in_green_in),
    .in_blue_in(in_blue_in), .out_stall(out_stall), .out_valid(out_valid),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_frame_last(out_frame_last)
  );
endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the streaming Sobel edge magnitude block: directed table then random frames
`timescale 1ns / 1ps
`default_nettype none
module tb;
  localparam int DW = sem_pkg::DIM_W;

  typedef struct {
    logic       func;
    logic [7:0] r, g, b;
    logic       chk;
    logic [7:0] er, eg, eb;
    logic       el;
  } pixel_row_t;

  typedef struct {
    logic [7:0] r, g, b;
    logic       last;
  } mag_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = sem_pkg::CFG_WIDTH;
  logic [DW-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  wire  in_stall;
  logic in_func = 1'b0;
  logic [7:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  wire  out_valid;
  logic out_stall = 1'b0;
  wire  [7:0] out_red_out, out_green_out, out_blue_out;
  wire  out_frame_last;

  sobel_edge_magnitude_rgb_core u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [DW-1:0] img_w = DW'(sem_pkg::MAX_WIDTH), img_h = DW'(sem_pkg::MAX_HEIGHT);
  logic [23:0] line_up [sem_pkg::MAX_WIDTH];
  logic [23:0] line_mid [sem_pkg::MAX_WIDTH];
  logic [23:0] win [3][3];
  int unsigned col_pos = 0, row_pos = 0, res_cnt = 0;
  mag_t mag_q [$];
  int   errors = 0;
  int   n_items = 0;

  function automatic logic [7:0] root_round(int unsigned s);
    int unsigned rt;
    rt = 0;
    while ((rt + 1) * (rt + 1) <= s) rt++;
    if (s - rt * rt > rt) rt++;
    return (rt > 255) ? 8'd255 : rt[7:0];
  endfunction

  function automatic int unsigned clampd(logic [DW-1:0] v, int unsigned m);
    if (v == 0) return 1;
    if (v > m) return m;
    return v;
  endfunction

  // advance the window by one item; returns 1 with a magnitude when one is due
  function automatic bit predict_edge(logic func, logic [23:0] px_in, output mag_t m);
    int unsigned w, h, r, c, col, ci, cj;
    logic [23:0] px, up, mid;
    bit started, done, ro[3], co[3], res;
    int p[3][3];
    int gx, gy;
    logic [7:0] mg[3];
    w = clampd(img_w, sem_pkg::MAX_WIDTH);
    h = clampd(img_h, sem_pkg::MAX_HEIGHT);
    r = row_pos; c = col_pos; col = c % sem_pkg::MAX_WIDTH;
    px = (!func && r < h) ? px_in : 24'd0;
    up = line_up[col]; mid = line_mid[col];
    line_up[col] = mid; line_mid[col] = px;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up; win[1][2] = mid; win[2][2] = px;
    started = (r >= 2) || (r == 1 && c >= 1);
    done = 0; res = 0; m = '{default: '0};
    if (started && res_cnt < w * h) begin
      ci = (c == 0) ? r - 2 : r - 1;
      cj = (c == 0) ? w - 1 : c - 1;
      ro[0] = ci != 0; ro[1] = 1; ro[2] = ci + 1 < h;
      co[0] = cj != 0; co[1] = 1; co[2] = cj + 1 < w;
      for (int ch = 0; ch < 3; ch++) begin
        for (int y = 0; y < 3; y++)
          for (int x = 0; x < 3; x++)
            p[y][x] = (ro[y] && co[x]) ? int'((win[y][x] >> (16 - 8 * ch)) & 24'hFF) : 0;
        gx = -p[0][0] + p[0][2] - 2 * p[1][0] + 2 * p[1][2] - p[2][0] + p[2][2];
        gy = -p[0][0] - 2 * p[0][1] - p[0][2] + p[2][0] + 2 * p[2][1] + p[2][2];
        mg[ch] = root_round(gx * gx + gy * gy);
      end
      res_cnt++;
      done = res_cnt >= w * h;
      m = '{mg[0], mg[1], mg[2], done};
      res = 1;
    end else if (started) done = 1;
    if (done) begin
      row_pos = 0; col_pos = 0; res_cnt = 0;
    end else if (c + 1 >= w) begin
      col_pos = 0; row_pos = r + 1;
    end else col_pos = c + 1;
    return res;
  endfunction

  task automatic write_reg(logic idx, logic [DW-1:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sem_pkg::CFG_WIDTH) img_w = v; else img_h = v;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (mag_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // send one item, queue its expectation (or the typed one if given)
  task automatic send_pixel(pixel_row_t t);
    mag_t m;
    int gap;
    gap = $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1; in_func <= t.func;
    in_red_in <= t.r; in_green_in <= t.g; in_blue_in <= t.b;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    if (predict_edge(t.func, {t.r, t.g, t.b}, m)) begin
      if (t.chk) m = '{t.er, t.eg, t.eb, t.el};
      mag_q.push_back(m);
    end
    n_items++;
  endtask

  always @(posedge clk) begin
    mag_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (mag_q.size() == 0) begin
        $display("%0t: unexpected item %h %h %h %b", $time, out_red_out,
                 out_green_out, out_blue_out, out_frame_last);
        errors++;
      end else begin
        e = mag_q.pop_front();
        if (e.r !== out_red_out || e.g !== out_green_out || e.b !== out_blue_out ||
            e.last !== out_frame_last) begin
          $display("%0t: expected %h %h %h %b, got %h %h %h %b", $time, e.r, e.g, e.b,
                   e.last, out_red_out, out_green_out, out_blue_out, out_frame_last);
          errors++;
        end
      end
    end
  end

  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (out_valid && out_stall) out_stall <= 1'b0;
      else if (out_valid && $urandom_range(0, 2) == 0) begin
        stall_left = $urandom_range(0, 18);
        out_stall <= (stall_left != 0);
      end else out_stall <= 1'b0;
    end
  end

  initial begin
    #40_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic random_frame(int unsigned w, int unsigned h, int mode, int unsigned cap);
    pixel_row_t t;
    int n;
    n = w * h + w + 1;
    if (cap != 0 && cap < n) n = cap;
    for (int i = 0; i < n; i++) begin
      t = '{default: '0};
      t.func = (i >= w * h) ? 1'b1 : ($urandom_range(0, 15) == 0);
      t.r = 8'($urandom); t.g = 8'($urandom); t.b = 8'($urandom);
      if (mode == 1) begin
        t.r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        t.g = ~t.r; t.b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      if (i >= w * h && $urandom_range(0, 4) == 0) t.func = 1'b0;
      send_pixel(t);
    end
  endtask

  pixel_row_t dir_tab [$];

  initial begin
    int unsigned w, h;
    for (int i = 0; i < sem_pkg::MAX_WIDTH; i++) begin
      line_up[i] = '0; line_mid[i] = '0;
    end
    win = '{default: '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // 1x1 frame: lone pixel has no gradient
    write_reg(sem_pkg::CFG_WIDTH, DW'(1));
    write_reg(sem_pkg::CFG_HEIGHT, DW'(1));
    dir_tab.push_back('{1'b0, 8'hFF, 8'h00, 8'hFF, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
    dir_tab.push_back('{1'b1, 8'h00, 8'h00, 8'h00, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
    dir_tab.push_back('{1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'd0, 8'd0, 8'd0, 1'b1});
    // 3x3 frame, bright centre: every result checked by predictor
    for (int i = 0; i < 9; i++)
      dir_tab.push_back('{1'b0, (i == 4) ? 8'hFF : 8'h00, 8'hFF, (i == 4) ? 8'h00 : 8'hFF,
                          1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
    for (int i = 0; i < 4; i++)
      dir_tab.push_back('{1'b1, 8'hAA, 8'h55, 8'h0F, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
    foreach (dir_tab[i]) begin
      if (i == 3) begin
        settle();
        write_reg(sem_pkg::CFG_WIDTH, DW'(3));
        write_reg(sem_pkg::CFG_HEIGHT, DW'(3));
      end
      send_pixel(dir_tab[i]);
    end
    settle();
    // out-of-range register values: zero means one, above max is clamped
    write_reg(sem_pkg::CFG_WIDTH, DW'(0));
    write_reg(sem_pkg::CFG_HEIGHT, 11'h7FF);
    for (int i = 0; i < 4; i++)
      send_pixel('{1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                   8'd0, 8'd0, 8'd0, 1'b0});
    settle();
    write_reg(sem_pkg::CFG_WIDTH, DW'(4));
    write_reg(sem_pkg::CFG_HEIGHT, DW'(1));
    random_frame(4, 1, 1, 0);
    settle();
    // widest row, cut short: shrinking the frame below the count ends it
    write_reg(sem_pkg::CFG_WIDTH, DW'(1024));
    write_reg(sem_pkg::CFG_HEIGHT, DW'(2));
    random_frame(1024, 2, 0, 1030);
    settle();
    write_reg(sem_pkg::CFG_WIDTH, DW'(1));
    write_reg(sem_pkg::CFG_HEIGHT, DW'(1));
    send_pixel('{1'b1, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 1'b0});
    settle();
    // tall narrow frame
    write_reg(sem_pkg::CFG_WIDTH, DW'(1));
    write_reg(sem_pkg::CFG_HEIGHT, DW'(40));
    random_frame(1, 40, 0, 0);
    settle();
    while (n_items < 1250) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 10);
      write_reg(sem_pkg::CFG_WIDTH, DW'(w));
      write_reg(sem_pkg::CFG_HEIGHT, DW'(h));
      random_frame(w, h, $urandom_range(0, 3) == 0, 0);
      settle();
    end
    settle();
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
